### hw/rtl/hcc_pkg.sv
// Shared types, constants and mod-26 helpers for the 3x3 Hill cipher block.
// No dependencies; imported by hcc_key, hcc_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hcc_pkg;

    localparam int unsigned MOD26      = 26;
    localparam int unsigned ASCII_A    = 65;
    localparam int unsigned LET_W      = 7;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned ACC_W      = 12;
    localparam int unsigned KEY_W      = 45;
    localparam int unsigned TDATA_W    = 24;
    localparam int unsigned LET_OFS    = 3 * MOD26 - ASCII_A;
    localparam int unsigned KEY_STAGES = 7;
    localparam int unsigned DLY_STAGES = KEY_STAGES;
    localparam int unsigned NSTG       = DLY_STAGES + 2;
    localparam int unsigned SUM_MAX    = 3 * (MOD26 - 1) * (MOD26 - 1);

    localparam logic [KEY_W-1:0] KEY_RESET = 45'd1099512676353;

    typedef logic [IDX_W-1:0]                 t_idx;
    typedef logic [ACC_W-1:0]                 t_acc;
    typedef logic [2:0][2:0][IDX_W-1:0]       t_mat;
    typedef logic [2:0][2:0][ACC_W-1:0]       t_amat;

    typedef struct packed {
        t_mat k;
        t_mat inv;
        logic key_invalid;
    } t_key_bus;

    typedef struct packed {
        logic                  mode;
        logic                  last;
        logic [2:0][IDX_W-1:0] v;
    } t_item;

    // reduce values below 26 * 128 by a chain of compare-subtract steps
    function automatic t_idx mod26(input t_acc x);
        t_acc r;
        r = x;
        for (int s = 6; s >= 0; s--) begin
            if (r >= (t_acc'(MOD26) << s)) begin
                r = r - (t_acc'(MOD26) << s);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic t_idx inv26(input t_idx d);
        t_idx r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hill_cipher_3x3_mod26.sv
// 3x3 Hill cipher over A..Z, top level; uses hcc_pkg, hcc_key and hcc_dp.
// Stages from input accept to output valid: 7 matched to the key schedule
// pipeline, one product stage, one mod-26 output register.
// Throughput: one word per cycle; the output register stalls the whole pipe.
// Reset (synchronous, active low) loads the identity key and empties the pipe;
// s_axis_tready rises in the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module hill_cipher_3x3_mod26 (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hcc_pkg::KEY_W-1:0]   i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [hcc_pkg::TDATA_W-1:0] s_axis_tdata,  // letter_0, letter_1, letter_2
    input  wire logic                        s_axis_tuser,  // mode
    input  wire logic                        s_axis_tlast,  // last_block
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [hcc_pkg::TDATA_W-1:0]      m_axis_tdata,  // out_letter_0..2
    output logic                             m_axis_tuser,  // key_invalid
    output logic                             m_axis_tlast   // last_out
);
    import hcc_pkg::*;

    t_key_bus                w_key;
    logic [2:0][LET_W-1:0]   w_in_let;
    logic [2:0][LET_W-1:0]   w_out_let;

    assign w_in_let = s_axis_tdata[3*LET_W-1:0];

    hcc_key u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_key       (w_key)
    );

    hcc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (w_key),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_mode        (s_axis_tuser),
        .i_last        (s_axis_tlast),
        .i_letters     (w_in_let),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_letters     (w_out_let),
        .o_key_invalid (m_axis_tuser),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {(TDATA_W - 3*LET_W)'(0), w_out_let};

endmodule

`default_nettype wire

### hw/rtl/hcc_key.sv
// Key register and key schedule pipeline: reduced key, cofactors, determinant,
// determinant inverse and inverse matrix. Depends on hcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcc_key (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hcc_pkg::KEY_W-1:0]  i_cfg_wdata,
    output hcc_pkg::t_key_bus               o_key
);
    import hcc_pkg::*;

    logic [KEY_W-1:0]      r_key;
    logic [KEY_STAGES:1]   r_kvld;
    t_mat                  r_k [1:KEY_STAGES];
    t_mat                  n_k1;
    t_amat                 r_craw2;
    t_amat                 n_craw2;
    t_mat                  r_cof3;
    t_mat                  n_cof3;
    t_mat                  r_cof4;
    t_mat                  r_cof5;
    t_acc                  r_draw4;
    t_acc                  n_draw4;
    t_idx                  r_det5;
    t_idx                  n_det5;
    t_idx                  r_dinv5;
    logic                  r_bad5;
    logic                  r_bad6;
    logic                  r_bad7;
    t_amat                 r_iraw6;
    t_amat                 n_iraw6;
    t_mat                  r_inv7;
    t_mat                  n_inv7;
    logic                  w_k1_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= KEY_RESET;
            r_kvld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
            r_kvld <= {r_kvld[KEY_STAGES-1:1], 1'b1};
        end
    end

    always_comb begin
        n_k1 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_k1[i][j] = r_key[IDX_W*(3*i+j) +: IDX_W];
                if (n_k1[i][j] >= t_idx'(MOD26)) begin
                    n_k1[i][j] = n_k1[i][j] - t_idx'(MOD26);
                end
            end
        end
    end

    always_comb begin
        n_craw2 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_craw2[i][j] = t_acc'(r_k[1][(i+1)%3][(j+1)%3]) * t_acc'(r_k[1][(i+2)%3][(j+2)%3])
                              + t_acc'(MOD26 * MOD26)
                              - t_acc'(r_k[1][(i+1)%3][(j+2)%3]) * t_acc'(r_k[1][(i+2)%3][(j+1)%3]);
            end
        end
    end

    always_comb begin
        n_cof3 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_cof3[i][j] = mod26(r_craw2[i][j]);
            end
        end
    end

    always_comb begin
        n_draw4 = '0;
        for (int j = 0; j < 3; j++) begin
            n_draw4 = n_draw4 + t_acc'(r_k[3][0][j]) * t_acc'(r_cof3[0][j]);
        end
    end

    assign n_det5 = mod26(r_draw4);

    always_comb begin
        n_iraw6 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_iraw6[i][j] = t_acc'(r_cof5[j][i]) * t_acc'(r_dinv5);
            end
        end
    end

    always_comb begin
        n_inv7 = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_inv7[i][j] = mod26(r_iraw6[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k[1] <= n_k1;
        for (int s = 2; s <= KEY_STAGES; s++) begin
            r_k[s] <= r_k[s-1];
        end
        r_craw2 <= n_craw2;
        r_cof3  <= n_cof3;
        r_cof4  <= r_cof3;
        r_draw4 <= n_draw4;
        r_cof5  <= r_cof4;
        r_det5  <= n_det5;
        r_dinv5 <= inv26(n_det5);
        r_bad5  <= (n_det5[0] == 1'b0) || (n_det5 == t_idx'(MOD26 / 2));
        r_iraw6 <= n_iraw6;
        r_bad6  <= r_bad5;
        r_inv7  <= n_inv7;
        r_bad7  <= r_bad6;
    end

    assign o_key.k           = r_k[KEY_STAGES];
    assign o_key.inv         = r_inv7;
    assign o_key.key_invalid = r_bad7;

    always_comb begin
        w_k1_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_k[1][i][j] >= t_idx'(MOD26)) begin
                    w_k1_ok = 1'b0;
                end
            end
        end
    end

    a_key_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kvld[1] |-> w_k1_ok)
        else $error("key entry not reduced below 26");

    a_det_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kvld[5] && !r_bad5 |-> mod26(t_acc'(r_det5) * t_acc'(r_dinv5)) == t_idx'(1))
        else $error("determinant inverse wrong");

    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kvld[5] |-> r_bad5 == (r_dinv5 == '0))
        else $error("key invalid flag disagrees with inverse table");

endmodule

`default_nettype wire

### hw/rtl/hcc_dp.sv
// Word pipeline: letter reduction, delay stages matched to the key schedule,
// vector-matrix product and final mod-26 / ASCII stage. Depends on hcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire hcc_pkg::t_key_bus                 i_key,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_mode,
    input  wire logic                              i_last,
    input  wire logic [2:0][hcc_pkg::LET_W-1:0]    i_letters,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [2:0][hcc_pkg::LET_W-1:0]         o_letters,
    output logic                                   o_key_invalid,
    output logic                                   o_last
);
    import hcc_pkg::*;

    logic                        r_run;
    logic [NSTG:1]               r_vld;
    t_item                       r_it [1:DLY_STAGES];
    t_item                       n_it1;
    logic [2:0][ACC_W-1:0]       r_sum;
    logic [2:0][ACC_W-1:0]       n_sum;
    t_mat                        w_m;
    logic                        r_bad8;
    logic                        r_last8;
    logic [2:0][LET_W-1:0]       r_out;
    logic                        r_bad9;
    logic                        r_last9;
    logic                        w_en;

    assign w_en    = !r_vld[NSTG] || i_ready;
    assign o_ready = w_en && r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_vld <= '0;
        end else begin
            r_run <= 1'b1;
            if (w_en) begin
                r_vld <= {r_vld[NSTG-1:1], i_valid && r_run};
            end
        end
    end

    always_comb begin
        n_it1      = '0;
        n_it1.mode = i_mode;
        n_it1.last = i_last;
        for (int i = 0; i < 3; i++) begin
            n_it1.v[i] = mod26(t_acc'(i_letters[i]) + t_acc'(LET_OFS));
        end
    end

    assign w_m = r_it[DLY_STAGES].mode ? i_key.inv : i_key.k;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_sum[j] = n_sum[j] + t_acc'(r_it[DLY_STAGES].v[i]) * t_acc'(w_m[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it[1] <= n_it1;
            for (int s = 2; s <= DLY_STAGES; s++) begin
                r_it[s] <= r_it[s-1];
            end
            r_sum   <= n_sum;
            r_bad8  <= i_key.key_invalid;
            r_last8 <= r_it[DLY_STAGES].last;
            for (int j = 0; j < 3; j++) begin
                r_out[j] <= LET_W'(mod26(r_sum[j])) + LET_W'(ASCII_A);
            end
            r_bad9  <= r_bad8;
            r_last9 <= r_last8;
        end
    end

    assign o_valid       = r_vld[NSTG];
    assign o_letters     = r_out;
    assign o_key_invalid = r_bad9;
    assign o_last        = r_last9;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG] |-> r_out[0] >= LET_W'(ASCII_A) && r_out[0] <= LET_W'(ASCII_A + MOD26 - 1)
                     && r_out[1] >= LET_W'(ASCII_A) && r_out[1] <= LET_W'(ASCII_A + MOD26 - 1)
                     && r_out[2] >= LET_W'(ASCII_A) && r_out[2] <= LET_W'(ASCII_A + MOD26 - 1))
        else $error("result letter out of range");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> r_sum[0] <= t_acc'(SUM_MAX) && r_sum[1] <= t_acc'(SUM_MAX)
                       && r_sum[2] <= t_acc'(SUM_MAX))
        else $error("product sum exceeds bound");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[NSTG-1] |=> r_vld[NSTG])
        else $error("word lost between product and output stage");

endmodule

`default_nettype wire
